// ===== rtl/rcmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rcmst_pkg
// Shared types and constants for the range chmin / range min store.
// ----------------------------------------------------------------------------
package rcmst_pkg;

    localparam int unsigned POS_W = 10;
    localparam int unsigned VAL_W = 31;
    localparam int unsigned TAG_W = 20;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // one stored node: written bit, value, tag
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
        logic [TAG_W-1:0] tag;
    } t_node;

    typedef struct packed {
        logic             cmd;
        logic [POS_W-1:0] range_low;
        logic [POS_W-1:0] range_high;
        logic [VAL_W-1:0] new_value;
        logic [TAG_W-1:0] tag;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] min_value;
        logic [TAG_W-1:0] min_tag;
        logic             empty_res;
    } t_rsp;

    // lexicographic pick of the lesser valid node
    function automatic t_node node_min2(input t_node a, input t_node b);
        t_node r;
        r = a;
        if (b.valid && (!a.valid || b.value < a.value ||
                        (b.value == a.value && b.tag < a.tag)))
            r = b;
        return r;
    endfunction

endpackage

// ===== rtl/rcmst_if.sv =====
// ----------------------------------------------------------------------------
// rcmst_req_if / rcmst_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface rcmst_req_if import rcmst_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rcmst_rsp_if import rcmst_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rcmst_mem.sv =====
// ----------------------------------------------------------------------------
// rcmst_mem
// Node store, one port, registered read, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module rcmst_mem import rcmst_pkg::*; #(
    parameter int unsigned ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_node             i_wdata,
    output t_node             o_rdata,
    output logic              o_clr_done
);
    t_node r_mem [2**ADDR_W];
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_done;

    // clearing sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {ADDR_W{1'b1}}) r_clr_done <= 1'b1;
        end
    end

    // storage port
    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

    assign o_clr_done = r_clr_done;
endmodule

// ===== rtl/range_chmin_min_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_chmin_min_segment_tree
// Range chmin / range minimum over LEAVES tagged positions, one node port.
// ----------------------------------------------------------------------------
// Query: walks up from the leaves, reading each visited node and folding it in.
// Update: read then write per leaf, then rebuild per inner node; a wide
//   range takes time in proportion to its width, set by the single node port.
// One transaction at a time; a waiting result sits in the output register and
//   only a query that reaches its own result stalls on it.
// Reset: synchronous active low; a clearing pass over the node store follows,
//   during which no request is taken.
module range_chmin_min_segment_tree import rcmst_pkg::*; #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rcmst_req_if.sink   i_req,
    rcmst_rsp_if.source o_rsp
);
    localparam int unsigned LW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int unsigned AW = LW + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LRD   = 10'b0000000010,
        S_LWR   = 10'b0000000100,
        S_RL    = 10'b0000001000,
        S_RR    = 10'b0000010000,
        S_RWR   = 10'b0000100000,
        S_QSTEP = 10'b0001000000,
        S_QRD   = 10'b0010000000,
        S_QACC  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [AW:0] r_l, n_l, r_r, n_r, r_a, n_a, r_b, n_b, r_i, n_i;
    logic [VAL_W-1:0] r_nv;
    logic [TAG_W-1:0] r_tg;
    t_node r_acc, n_acc, r_left, n_left;
    logic  r_pick, n_pick; // which side was read in query
    t_rsp  r_rsp, n_rsp;
    logic  r_ovalid, n_ovalid;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_node         mem_wdata, mem_rdata, best;
    logic          clr_done;

    rcmst_mem #(.ADDR_W(AW)) u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata), .o_clr_done(clr_done)
    );

    // clamp and emptiness check on the incoming request
    logic [AW:0] in_lo, in_hi;
    logic        in_empty;
    always_comb begin
        in_lo = (AW+1)'(i_req.data.range_low);
        in_hi = (AW+1)'(i_req.data.range_high);
        if (in_hi > (AW+1)'(LEAVES - 1)) in_hi = (AW+1)'(LEAVES - 1);
        in_empty = (in_lo >= (AW+1)'(LEAVES)) || (in_hi < in_lo);
    end

    assign i_req.ready = (r_state == S_IDLE) && clr_done;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    // shared compare unit
    assign best = node_min2(r_left, mem_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_l <= n_l; r_r <= n_r; r_a <= n_a; r_b <= n_b; r_i <= n_i;
        r_acc <= n_acc; r_left <= n_left; r_pick <= n_pick; r_rsp <= n_rsp;
        if (i_req.valid && i_req.ready) begin
            r_nv  <= i_req.data.new_value;
            r_tg  <= i_req.data.tag;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_l = r_l; n_r = r_r; n_a = r_a; n_b = r_b;
        n_i = r_i; n_acc = r_acc; n_left = r_left; n_pick = r_pick;
        n_rsp = r_rsp; n_ovalid = r_ovalid;
        mem_we = 1'b0; mem_addr = r_i[AW-1:0]; mem_wdata = '0;
        if (o_rsp.valid && o_rsp.ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_acc = '0;
                    n_l = (AW+1)'(LEAVES) + in_lo;
                    n_r = (AW+1)'(LEAVES) + in_hi + 1'b1;
                    n_i = (AW+1)'(LEAVES) + in_lo;
                    n_a = ((AW+1)'(LEAVES) + in_lo) >> 1;
                    n_b = ((AW+1)'(LEAVES) + in_hi) >> 1;
                    if (in_empty)
                        n_state = (i_req.data.cmd == CMD_QUERY) ? S_OUT : S_IDLE;
                    else
                        n_state = (i_req.data.cmd == CMD_QUERY) ? S_QSTEP : S_LRD;
                end
            end
            // leaf read then conditional write
            S_LRD: n_state = S_LWR;
            S_LWR: begin
                if (!mem_rdata.valid || mem_rdata.value > r_nv) begin
                    mem_we = 1'b1;
                    mem_wdata = '{valid: 1'b1, value: r_nv, tag: r_tg};
                end
                if (r_i == r_r - 1'b1) begin
                    n_i = r_a;
                    n_state = S_RL;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_LRD;
                end
            end
            // rebuild: read left child, right child, write parent
            S_RL: begin
                mem_addr = AW'({r_i, 1'b0});
                n_state = S_RR;
            end
            S_RR: begin
                mem_addr = AW'({r_i, 1'b1});
                n_left = mem_rdata;
                n_state = S_RWR;
            end
            S_RWR: begin
                mem_we = 1'b1;
                mem_wdata = best.valid ? best : '0;
                if (r_i == r_b) begin
                    if (r_b <= 1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_a = (r_a >> 1) < 1 ? (AW+1)'(1) : (r_a >> 1);
                        n_b = r_b >> 1;
                        n_i = (r_a >> 1) < 1 ? (AW+1)'(1) : (r_a >> 1);
                        n_state = S_RL;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_RL;
                end
            end
            // query walk
            S_QSTEP: begin
                if (r_l >= r_r) begin
                    n_state = S_OUT;
                end else if (r_l[0]) begin
                    n_i = r_l; n_l = r_l + 1'b1; n_pick = 1'b0;
                    n_state = S_QRD;
                end else if (r_r[0]) begin
                    n_i = r_r - 1'b1; n_r = r_r - 1'b1; n_pick = 1'b1;
                    n_state = S_QRD;
                end else begin
                    n_l = r_l >> 1; n_r = r_r >> 1;
                end
            end
            S_QRD: begin
                n_left = r_acc;
                n_state = S_QACC;
            end
            S_QACC: begin
                n_acc = best;
                // after the right side, or left with no right work, halve
                if (r_pick || !r_r[0] || r_l >= r_r) begin
                    n_l = r_l >> 1; n_r = r_r >> 1;
                    n_state = S_QSTEP;
                end else begin
                    n_i = r_r - 1'b1; n_r = r_r - 1'b1; n_pick = 1'b1;
                    n_state = S_QRD;
                end
            end
            // load the output register once it is free or being emptied
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_rsp.empty_res = !r_acc.valid;
                    n_rsp.min_value = r_acc.valid ? r_acc.value : '0;
                    n_rsp.min_tag   = r_acc.valid ? r_acc.tag : '0;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
